// File: design/aip_pkg.sv
package aip_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int ACC_W   = 64;
    localparam int POS_W   = 12;
    localparam int POS_MAX = 4095;
    localparam int OUT_W   = 80;
    localparam int OUT_PAD = OUT_W - (ACC_W + POS_W + 1);

    // Defaults for the top-level parameters
    localparam int AIP_MAX_LENGTH  = 4095;
    localparam int AIP_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic REG_RADIX       = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    // Radix codes
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

    // Parser phase
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGNWS,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Configuration as seen by the parser
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               signed_mode;
    } cfg_t;

    // One classified character
    typedef struct packed {
        logic [DIGIT_W-1:0] weight;
        logic               is_alnum;
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               last;
    } char_item_t;

    // Parser status towards the top level
    typedef struct packed {
        logic pop;
        logic result_load;
    } back_status_t;

endpackage

// File: design/aip_front.sv
module aip_front
    import aip_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,     // [7:0] char_code
    input  logic              s_tlast,     // last_char
    input  logic              q_full,
    output logic              push,
    output char_item_t        item
);

    // Accept a beat whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify the character
    always_comb
    begin
        item             = '0;
        item.last        = s_tlast;
        item.is_space    = s_tdata inside {CH_SPACE, [CH_TAB:CH_CR]};
        item.is_plus     = (s_tdata == CH_PLUS);
        item.is_minus    = (s_tdata == CH_MINUS);
        item.is_zero     = (s_tdata == CH_0);
        item.is_x        = (s_tdata == CH_LC_X) || (s_tdata == CH_UC_X);
        if (s_tdata inside {[CH_0:CH_9]})
        begin
            item.is_alnum = 1'b1;
            item.weight   = DIGIT_W'(s_tdata - CH_0);
        end
        else if (s_tdata inside {[CH_LC_A:CH_LC_Z]})
        begin
            item.is_alnum = 1'b1;
            item.weight   = DIGIT_W'(s_tdata - CH_LC_A) + DIGIT_W'(10);
        end
        else if (s_tdata inside {[CH_UC_A:CH_UC_Z]})
        begin
            item.is_alnum = 1'b1;
            item.weight   = DIGIT_W'(s_tdata - CH_UC_A) + DIGIT_W'(10);
        end
    end

endmodule

// File: design/aip_queue.sv
module aip_queue
    import aip_pkg::*;
#(
    parameter int DEPTH = AIP_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output char_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    char_item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/aip_back.sv
module aip_back
    import aip_pkg::*;
#(
    parameter int MAX_LENGTH = AIP_MAX_LENGTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  char_item_t       item,
    output back_status_t     status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [63:0] parsed_value, [75:64] consumed_count,
                                        // [76] no_digits
);

    localparam int CAP_INT = (MAX_LENGTH < POS_MAX) ? MAX_LENGTH : POS_MAX;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAP_INT);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_W-1:0]     acc_step;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W-1:0]     end_reg;
    logic [POS_W-1:0]     end_next;
    logic [POS_W-1:0]     end_step;
    logic                 neg_reg;
    logic                 neg_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic                 seen_reg;
    logic                 seen_next;
    logic                 seen_step;

    logic                 out_valid_reg;
    logic [ACC_W-1:0]     out_value_reg;
    logic [POS_W-1:0]     out_count_reg;
    logic                 out_nod_reg;

    logic                 take_item;
    logic                 result_load;
    logic [POS_W-1:0]     step_pos;
    logic [RADIX_W-1:0]   start_radix;
    logic [RADIX_W-1:0]   use_radix;
    logic [ACC_W-1:0]     product;
    logic [ACC_W-1:0]     digit_term;
    logic [ACC_W-1:0]     acc_mac;
    logic                 digit_ok;
    logic                 zero_prefix;
    logic                 sign_taken;
    phase_t               start_phase;
    phase_t               digit_phase;

    // Hold the last beat of a string while the result register is still full
    assign take_item   = q_valid && (!item.last || !out_valid_reg || m_tready);
    assign result_load = take_item && item.last;
    assign status.pop         = take_item;
    assign status.result_load = result_load;

    // Classify against the current configuration and phase
    always_comb
    begin
        step_pos    = (pos_reg < POS_CAP) ? pos_reg + POS_W'(1) : POS_CAP;
        start_radix = (cfg.radix == RADIX_AUTO) ? RADIX_DEC : cfg.radix;
        use_radix   = ((phase_reg == PH_LEAD) || (phase_reg == PH_SIGNWS)) ? start_radix
                                                                           : radix_reg;
        product     = acc_reg * ACC_W'(use_radix);
        digit_term  = ACC_W'(item.weight);
        acc_mac     = neg_reg ? product - digit_term : product + digit_term;
        digit_ok    = item.is_alnum && (item.weight < use_radix);
        zero_prefix = ((cfg.radix == RADIX_AUTO) || (cfg.radix == RADIX_HEX)) && item.is_zero;
        sign_taken  = cfg.signed_mode && (item.is_plus || item.is_minus);
        digit_phase = digit_ok ? PH_DIGITS : PH_DONE;
        start_phase = zero_prefix ? PH_ZERO : digit_phase;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take_item)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (sign_taken)
                    begin
                        phase_next = PH_SIGNWS;
                    end
                    else if (!item.is_space)
                    begin
                        phase_next = start_phase;
                    end
                end
                PH_SIGNWS:
                begin
                    if (!item.is_space)
                    begin
                        phase_next = start_phase;
                    end
                end
                PH_ZERO:
                begin
                    phase_next = item.is_x ? PH_DIGITS : digit_phase;
                end
                PH_DIGITS:
                begin
                    phase_next = digit_phase;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_LEAD;
                end
            endcase
            if (item.last)
            begin
                phase_next = PH_LEAD;
            end
        end
    end

    // Datapath updates for the taken beat
    always_comb
    begin
        acc_step   = acc_reg;
        end_step   = end_reg;
        seen_step  = seen_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        pos_next   = pos_reg;
        if (take_item)
        begin
            pos_next = step_pos;
            case (phase_reg)
                PH_LEAD, PH_SIGNWS:
                begin
                    if ((phase_reg == PH_LEAD) && sign_taken)
                    begin
                        neg_next = item.is_minus;
                    end
                    else if (!item.is_space)
                    begin
                        if (zero_prefix)
                        begin
                            radix_next = (cfg.radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                            acc_step   = '0;
                            seen_step  = 1'b1;
                            end_step   = step_pos;
                        end
                        else
                        begin
                            radix_next = start_radix;
                            if (digit_ok)
                            begin
                                acc_step  = acc_mac;
                                seen_step = 1'b1;
                                end_step  = step_pos;
                            end
                        end
                    end
                end
                PH_ZERO, PH_DIGITS:
                begin
                    if ((phase_reg == PH_ZERO) && item.is_x)
                    begin
                        radix_next = RADIX_HEX;
                        seen_step  = 1'b0;
                    end
                    else if (digit_ok)
                    begin
                        acc_step  = acc_mac;
                        seen_step = 1'b1;
                        end_step  = step_pos;
                    end
                end
                default:
                begin
                    acc_step = acc_reg;
                end
            endcase
        end
        acc_next  = acc_step;
        end_next  = end_step;
        seen_next = seen_step;
        // Return to the start of a string after its last beat
        if (result_load)
        begin
            acc_next   = '0;
            end_next   = '0;
            seen_next  = 1'b0;
            neg_next   = 1'b0;
            radix_next = '0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            pos_reg   <= '0;
            end_reg   <= '0;
            neg_reg   <= 1'b0;
            radix_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            seen_reg  <= seen_next;
        end
    end

    // Result register: load on the last beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_value_reg <= seen_step ? acc_step : '0;
            out_count_reg <= seen_step ? end_step : '0;
            out_nod_reg   <= !seen_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_nod_reg, out_count_reg, out_value_reg};

endmodule

// File: design/ascii_integer_parser.sv
// ascii_integer_parser: converts a character stream to a 64-bit integer.
//
// Input channel s_*: one character per beat in s_tdata[7:0]; s_tlast marks
// the final character of a string. Output channel m_*: one result beat per
// string, sent after its last character: parsed_value in m_tdata[63:0],
// consumed_count in [75:64] and no_digits in [76].
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 radix,
// 1 signed mode) at the clock edge; write only while no string is in flight.
//
// Throughput is one character per cycle while the output does not stall: the
// front classifies each beat into a short queue and the back runs one
// multiply-add by the radix per cycle. A result appears on m_tvalid in the
// cycle after its last character is taken. Reset sets radix 10 and signed
// mode on, empties the queue and puts the parser at the start of a string.
// When the receiver stalls, the result register holds its beat; the back
// stops at the next last character, the queue fills and s_tready drops.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int MAX_LENGTH  = AIP_MAX_LENGTH,
    parameter int QUEUE_DEPTH = AIP_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [RADIX_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,     // [7:0] char_code
    input  logic               s_tlast,     // last_char
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata      // [63:0] parsed_value, [75:64] consumed_count,
                                            // [76] no_digits
);

    localparam int CAP_INT = (MAX_LENGTH < POS_MAX) ? MAX_LENGTH : POS_MAX;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAP_INT);

    logic [RADIX_W-1:0] radix_reg;
    logic               signed_mode_reg;
    cfg_t               cfg;
    logic               push;
    logic               q_full;
    logic               q_valid;
    char_item_t         push_item;
    char_item_t         head_item;
    back_status_t       back_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RADIX:       radix_reg       <= cfg_wdata;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default:         radix_reg       <= radix_reg;
            endcase
        end
    end

    assign cfg.radix       = radix_reg;
    assign cfg.signed_mode = signed_mode_reg;

    aip_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    aip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (back_status.pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    aip_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .item     (head_item),
        .status   (back_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // A result with no digits carries neither value nor count
    a_nod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[ACC_W+POS_W] |-> (m_tdata[ACC_W+POS_W-1:0] == '0))
        else $error("no-digits result carries a value or count");

    // Count never passes the position cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ACC_W+POS_W-1:ACC_W] <= POS_CAP))
        else $error("consumed count beyond cap");

    // A taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !back_status.result_load |=> !m_tvalid)
        else $error("result repeated after it was taken");

    // The parser only takes beats that are in the queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |-> q_valid)
        else $error("pop from an empty queue");
`endif

endmodule
